[sv/iirdf1_pkg.sv]
// ----------------------------------------------------------------------------
// iirdf1_pkg
// Shared widths, register codes and types for the direct form I biquad.
// ----------------------------------------------------------------------------
package iirdf1_pkg;

    // sample and coefficient formats (Q1.15 samples, Q4.14 coefficients)
    localparam int SampleW   = 16;
    localparam int CoefW     = 18;
    localparam int CoefFrac  = 14;
    localparam int TapCountW = 2;
    localparam int CfgIndexW = 3;

    // product, accumulator and post-shift widths
    localparam int ProdW  = SampleW + CoefW;
    localparam int AccW   = ProdW + 3;
    localparam int ShiftW = AccW - CoefFrac;

    // register reset values
    localparam logic signed [CoefW-1:0]  FfCoef0Reset  = CoefW'(16384);
    localparam logic [TapCountW-1:0]     TapCountReset = TapCountW'(1);

    // saturation limits on the shifted sum
    localparam logic signed [ShiftW-1:0] SatMax =
        {{(ShiftW-SampleW+1){1'b0}}, {(SampleW-1){1'b1}}};
    localparam logic signed [ShiftW-1:0] SatMin =
        {{(ShiftW-SampleW+1){1'b1}}, {(SampleW-1){1'b0}}};

    // configuration register indexes
    typedef enum logic [CfgIndexW-1:0] {
        REG_FF_COEF_0,
        REG_FF_COEF_1,
        REG_FF_COEF_2,
        REG_FB_COEF_1,
        REG_FB_COEF_2,
        REG_FF_TAP_COUNT,
        REG_FB_TAP_COUNT
    } cfg_reg_t;

    // coefficient set with per-tap enables, config block to datapath
    typedef struct packed {
        logic signed [CoefW-1:0] ff0;
        logic signed [CoefW-1:0] ff1;
        logic signed [CoefW-1:0] ff2;
        logic signed [CoefW-1:0] fb1;
        logic signed [CoefW-1:0] fb2;
        logic                    ff1_en;
        logic                    ff2_en;
        logic                    fb1_en;
        logic                    fb2_en;
    } coef_set_t;

    // filter history, newest first
    typedef struct packed {
        logic signed [SampleW-1:0] x1;
        logic signed [SampleW-1:0] x2;
        logic signed [SampleW-1:0] y1;
        logic signed [SampleW-1:0] y2;
    } hist_t;

endpackage

[sv/iirdf1_cfg_regs.sv]
// ----------------------------------------------------------------------------
// iirdf1_cfg_regs
// Coefficient and tap count registers, decoded into a coefficient set.
// ----------------------------------------------------------------------------
module iirdf1_cfg_regs
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [iirdf1_pkg::CfgIndexW-1:0]     cfg_index,
    input  logic [iirdf1_pkg::CoefW-1:0]         cfg_data,
    output iirdf1_pkg::coef_set_t                coefs
);

    logic signed [iirdf1_pkg::CoefW-1:0]     ff0_reg;
    logic signed [iirdf1_pkg::CoefW-1:0]     ff1_reg;
    logic signed [iirdf1_pkg::CoefW-1:0]     ff2_reg;
    logic signed [iirdf1_pkg::CoefW-1:0]     fb1_reg;
    logic signed [iirdf1_pkg::CoefW-1:0]     fb2_reg;
    logic [iirdf1_pkg::TapCountW-1:0]        ff_count_reg;
    logic [iirdf1_pkg::TapCountW-1:0]        fb_count_reg;

    // register writes, unknown indexes dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ff0_reg      <= iirdf1_pkg::FfCoef0Reset;
            ff1_reg      <= '0;
            ff2_reg      <= '0;
            fb1_reg      <= '0;
            fb2_reg      <= '0;
            ff_count_reg <= iirdf1_pkg::TapCountReset;
            fb_count_reg <= iirdf1_pkg::TapCountReset;
        end
        else if (cfg_we)
        begin
            unique case (iirdf1_pkg::cfg_reg_t'(cfg_index))
                iirdf1_pkg::REG_FF_COEF_0:    ff0_reg <= cfg_data;
                iirdf1_pkg::REG_FF_COEF_1:    ff1_reg <= cfg_data;
                iirdf1_pkg::REG_FF_COEF_2:    ff2_reg <= cfg_data;
                iirdf1_pkg::REG_FB_COEF_1:    fb1_reg <= cfg_data;
                iirdf1_pkg::REG_FB_COEF_2:    fb2_reg <= cfg_data;
                iirdf1_pkg::REG_FF_TAP_COUNT:
                    ff_count_reg <= cfg_data[iirdf1_pkg::TapCountW-1:0];
                iirdf1_pkg::REG_FB_TAP_COUNT:
                    fb_count_reg <= cfg_data[iirdf1_pkg::TapCountW-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // tap enables: count 2 adds tap one, count 3 adds tap two
    always_comb
    begin
        coefs.ff0    = ff0_reg;
        coefs.ff1    = ff1_reg;
        coefs.ff2    = ff2_reg;
        coefs.fb1    = fb1_reg;
        coefs.fb2    = fb2_reg;
        coefs.ff1_en = ff_count_reg[1];
        coefs.ff2_en = (ff_count_reg == 2'd3);
        coefs.fb1_en = fb_count_reg[1];
        coefs.fb2_en = (fb_count_reg == 2'd3);
    end

endmodule

[sv/iirdf1_mac.sv]
// ----------------------------------------------------------------------------
// iirdf1_mac
// Five parallel products, exact sum, round to the sample grid and saturate.
// ----------------------------------------------------------------------------
module iirdf1_mac
(
    input  logic signed [iirdf1_pkg::SampleW-1:0] sample,
    input  logic                                  block_start,
    input  iirdf1_pkg::hist_t                     hist,
    input  iirdf1_pkg::coef_set_t                 coefs,
    output logic signed [iirdf1_pkg::SampleW-1:0] result,
    output logic                                  clip
);

    localparam int ProdW  = iirdf1_pkg::ProdW;
    localparam int AccW   = iirdf1_pkg::AccW;
    localparam int ShiftW = iirdf1_pkg::ShiftW;
    localparam int ExtW   = AccW - ProdW;

    logic signed [iirdf1_pkg::SampleW-1:0] x1;
    logic signed [iirdf1_pkg::SampleW-1:0] x2;
    logic signed [iirdf1_pkg::SampleW-1:0] y1;
    logic signed [iirdf1_pkg::SampleW-1:0] y2;
    logic signed [iirdf1_pkg::CoefW-1:0]   b1;
    logic signed [iirdf1_pkg::CoefW-1:0]   b2;
    logic signed [iirdf1_pkg::CoefW-1:0]   a1;
    logic signed [iirdf1_pkg::CoefW-1:0]   a2;
    logic signed [ProdW-1:0]               p0;
    logic signed [ProdW-1:0]               p1;
    logic signed [ProdW-1:0]               p2;
    logic signed [ProdW-1:0]               q1;
    logic signed [ProdW-1:0]               q2;
    logic signed [AccW-1:0]                acc;
    logic signed [AccW-1:0]                rounded;
    logic signed [ShiftW-1:0]              shifted;

    // start of block sees an empty history
    assign x1 = block_start ? '0 : hist.x1;
    assign x2 = block_start ? '0 : hist.x2;
    assign y1 = block_start ? '0 : hist.y1;
    assign y2 = block_start ? '0 : hist.y2;

    // unused taps weigh zero
    assign b1 = coefs.ff1_en ? coefs.ff1 : '0;
    assign b2 = coefs.ff2_en ? coefs.ff2 : '0;
    assign a1 = coefs.fb1_en ? coefs.fb1 : '0;
    assign a2 = coefs.fb2_en ? coefs.fb2 : '0;

    // products
    assign p0 = sample * coefs.ff0;
    assign p1 = x1 * b1;
    assign p2 = x2 * b2;
    assign q1 = y1 * a1;
    assign q2 = y2 * a2;

    // exact sum, feedback subtracted
    assign acc = $signed({{ExtW{p0[ProdW-1]}}, p0})
               + $signed({{ExtW{p1[ProdW-1]}}, p1})
               + $signed({{ExtW{p2[ProdW-1]}}, p2})
               - $signed({{ExtW{q1[ProdW-1]}}, q1})
               - $signed({{ExtW{q2[ProdW-1]}}, q2});

    // add half an lsb then floor shift
    assign rounded = acc + $signed({{(AccW-iirdf1_pkg::CoefFrac){1'b0}}, 1'b1,
                                    {(iirdf1_pkg::CoefFrac-1){1'b0}}});
    assign shifted = rounded[AccW-1:iirdf1_pkg::CoefFrac];

    // saturate to the sample range
    always_comb
    begin
        priority if (shifted > iirdf1_pkg::SatMax)
        begin
            result = iirdf1_pkg::SatMax[iirdf1_pkg::SampleW-1:0];
            clip   = 1'b1;
        end
        else if (shifted < iirdf1_pkg::SatMin)
        begin
            result = iirdf1_pkg::SatMin[iirdf1_pkg::SampleW-1:0];
            clip   = 1'b1;
        end
        else
        begin
            result = shifted[iirdf1_pkg::SampleW-1:0];
            clip   = 1'b0;
        end
    end

endmodule

[sv/iir_filter_direct_form_one_unit.sv]
// ----------------------------------------------------------------------------
// iir_filter_direct_form_one_unit
// Direct form I biquad on Q1.15 samples with Q4.14 coefficients.
// ----------------------------------------------------------------------------
//  channel  | direction | payload
//  s_axis   | in        | tdata: sample_in[15:0]; tuser: block_start
//  m_axis   | out       | tdata: sample_out[15:0]; tuser: clipped
//  cfg      | in        | write only: cfg_we, cfg_index[2:0], cfg_data[17:0]
//
//  One word per cycle while m_axis does not stall. The input register feeds the
//  combinational multiply-accumulate and saturation, the output register holds
//  the result; the feedback history updates as a result is registered, so the
//  next word sees it the cycle after.
//  A stall on m_axis holds the input register and the history; s_axis keeps
//  taking words while that register is free. Reset clears history and returns config to its reset values.
// ----------------------------------------------------------------------------
module iir_filter_direct_form_one_unit
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    // slave side
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [iirdf1_pkg::SampleW-1:0]        s_axis_tdata,  // sample_in
    input  logic                                  s_axis_tuser,  // block_start
    // master side
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [iirdf1_pkg::SampleW-1:0]        m_axis_tdata,  // sample_out
    output logic                                  m_axis_tuser,  // clipped
    // configuration
    input  logic                                  cfg_we,
    input  logic [iirdf1_pkg::CfgIndexW-1:0]      cfg_index,
    input  logic [iirdf1_pkg::CoefW-1:0]          cfg_data
);

    iirdf1_pkg::coef_set_t                 coefs;
    iirdf1_pkg::hist_t                     hist_reg;
    iirdf1_pkg::hist_t                     hist_next;
    logic                                  in_valid_reg;
    logic signed [iirdf1_pkg::SampleW-1:0] in_sample_reg;
    logic                                  in_start_reg;
    logic                                  out_valid_reg;
    logic [iirdf1_pkg::SampleW-1:0]        out_sample_reg;
    logic                                  out_clip_reg;
    logic signed [iirdf1_pkg::SampleW-1:0] mac_result;
    logic                                  mac_clip;
    logic                                  advance;
    logic                                  take_in;

    iirdf1_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .coefs     (coefs)
    );

    iirdf1_mac u_mac
    (
        .sample      (in_sample_reg),
        .block_start (in_start_reg),
        .hist        (hist_reg),
        .coefs       (coefs),
        .result      (mac_result),
        .clip        (mac_clip)
    );

    // handshake: input word moves on when the output slot is free or drains
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign take_in       = s_axis_tvalid && s_axis_tready;

    // history shift, cleared at block start
    always_comb
    begin
        hist_next.x1 = in_sample_reg;
        hist_next.x2 = in_start_reg ? '0 : hist_reg.x1;
        hist_next.y1 = mac_result;
        hist_next.y2 = in_start_reg ? '0 : hist_reg.y1;
    end

    // control and history state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            hist_reg      <= '0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                hist_reg      <= hist_next;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            in_sample_reg <= s_axis_tdata;
            in_start_reg  <= s_axis_tuser;
        end
        if (advance)
        begin
            out_sample_reg <= mac_result;
            out_clip_reg   <= mac_clip;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_sample_reg;
    assign m_axis_tuser  = out_clip_reg;

endmodule
